>>> rtl/udiv32_pkg.sv
// Shared types and constants for the 32-bit unsigned divider.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package udiv32_pkg;

  // Operand and result width, and the width of the step counter.
  localparam int DATA_WIDTH = 32;
  localparam int CNT_WIDTH  = $clog2(DATA_WIDTH);

  // Payload of one input transfer.
  typedef struct packed {
    logic [DATA_WIDTH-1:0] dividend;
    logic [DATA_WIDTH-1:0] divisor;
  } udiv32_in_t;

  // Payload of one result transfer.
  typedef struct packed {
    logic [DATA_WIDTH-1:0] quotient;
    logic [DATA_WIDTH-1:0] remainder;
    logic                  divide_by_zero;
  } udiv32_out_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } udiv32_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
  } udiv32_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
  } udiv32_status_t;

endpackage

`default_nettype wire

>>> rtl/unsigned_divider_32_top.sv
// Top level of the 32-bit unsigned divider: joins controller and datapath.
// Depends on udiv32_pkg, udiv32_ctrl and udiv32_dp.
`default_nettype none

// An item is transferred at a rising edge where start is high and busy is low.
// The divider produces one quotient bit per cycle through a single shared
// subtractor, so each item first steps with busy high, one step per quotient
// bit, then has a single cycle with done high and the result on the result
// port. The receiver cannot stall: the result is valid only during that done
// cycle and must be captured then. The next item may be transferred in the
// done cycle, but not while busy is high. A zero divisor sets divide_by_zero,
// with an all-ones quotient and the dividend as the remainder.
module unsigned_divider_32_top
  import udiv32_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire udiv32_in_t operand,
  output logic            done,
  output udiv32_out_t     result
);

  udiv32_cmd_t    cmd;
  udiv32_status_t status;

  // Sequencing.
  udiv32_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // Arithmetic.
  udiv32_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .operand (operand),
    .status  (status),
    .result  (result)
  );

endmodule

`default_nettype wire

>>> rtl/udiv32_dp.sv
// Datapath of the divider: partial remainder, quotient shift register,
// divisor and step counter. Depends on udiv32_pkg.
`default_nettype none

module udiv32_dp
  import udiv32_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire udiv32_cmd_t    cmd,
  input  wire udiv32_in_t     operand,
  output udiv32_status_t      status,
  output udiv32_out_t         result
);

  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH-1:0] rem_next;
  logic [DATA_WIDTH-1:0] quo;
  logic [DATA_WIDTH-1:0] quo_next;
  logic [DATA_WIDTH-1:0] dvs;
  logic                  dz;
  logic [CNT_WIDTH-1:0]  cnt;
  logic [CNT_WIDTH-1:0]  cnt_next;
  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH+1:0] diff;
  logic                  fits;

  // One restoring step: shift in the next dividend bit and try a subtraction.
  // With a zero divisor every trial succeeds, which leaves an all-ones quotient
  // and the dividend as the remainder.
  always_comb begin
    shifted  = {rem, quo[DATA_WIDTH-1]};
    diff     = {1'b0, shifted} - {2'b00, dvs};
    fits     = ~diff[DATA_WIDTH+1];
    rem_next = fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
    quo_next = {quo[DATA_WIDTH-2:0], fits};
    cnt_next = cnt - CNT_WIDTH'(1);
  end

  // Operand registers, loaded on an input transfer and updated once per step.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem <= '0;
      quo <= operand.dividend;
      dvs <= operand.divisor;
      dz  <= (operand.divisor == '0);
    end else if (cmd.step) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  // Step counter, counting down to the final quotient bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load) begin
      cnt <= CNT_WIDTH'(DATA_WIDTH - 1);
    end else if (cmd.step) begin
      cnt <= cnt_next;
    end
  end

  // Status and result outputs.
  assign status.last           = (cnt == '0);
  assign result.quotient       = quo;
  assign result.remainder      = rem;
  assign result.divide_by_zero = dz;

  // A load always restarts the counter at the top.
  a_load_count : assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (cnt == CNT_WIDTH'(DATA_WIDTH - 1)))
    else $error("step counter not restarted by load");

  // The partial remainder stays below a nonzero divisor after every step.
  a_rem_bound : assert property (@(posedge clk) disable iff (rst)
    (cmd.step && !cmd.load && !dz) |=> (rem < dvs))
    else $error("partial remainder not below divisor");

  // A zero divisor drives every quotient bit to one.
  a_dz_quotient : assert property (@(posedge clk) disable iff (rst)
    (cmd.step && !cmd.load && dz && status.last) |=> (quo == '1))
    else $error("zero divisor quotient not all ones");

endmodule

`default_nettype wire

>>> rtl/udiv32_ctrl.sv
// Controller of the divider: sequences load, the bit steps and the result
// strobe. Depends on udiv32_pkg.
`default_nettype none

module udiv32_ctrl
  import udiv32_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire udiv32_status_t status,
  output udiv32_cmd_t         cmd,
  output logic                busy,
  output logic                done
);

  udiv32_state_t state;
  udiv32_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (status.last) state_next = ST_DONE;
      end
      ST_DONE: begin
        state_next = start ? ST_RUN : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs: a new transfer may be taken while the previous result is shown.
  always_comb begin
    busy     = 1'b0;
    done     = 1'b0;
    cmd.load = 1'b0;
    cmd.step = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd.load = start;
      end
      ST_RUN: begin
        busy     = 1'b1;
        cmd.step = 1'b1;
      end
      ST_DONE: begin
        done     = 1'b1;
        cmd.load = start;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // The result strobe follows directly on the final step.
  a_done_after_last : assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && status.last) |=> done)
    else $error("result strobe missing after final step");

  // The strobe is only ever raised straight out of the stepping state.
  a_done_from_run : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_RUN))
    else $error("result strobe without a completed division");

  // Load and step are never issued together.
  a_cmd_exclusive : assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && cmd.step))
    else $error("load and step issued in the same cycle");

endmodule

`default_nettype wire

>>> sim/udiv32_checker.sv
// Result checker for the 32-bit unsigned divider: predicts each quotient and remainder.
// Depends on udiv32_pkg for the operand and result payload types.
`timescale 1ns / 100ps

module udiv32_checker
  import udiv32_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire udiv32_in_t  operand,
  input  wire logic        done,
  input  wire udiv32_out_t result,
  output int               error_count,
  output int               pending,
  output int               checked,
  output int               zero_divides
);

  // Expected results, oldest first, one per accepted operand transfer.
  udiv32_out_t pending_divisions[$];

  // Truncating division; a zero divisor gives all ones and hands the dividend back.
  function automatic udiv32_out_t predict_division(udiv32_in_t op);
    udiv32_out_t r;
    if (op.divisor == '0) begin
      r.quotient       = '1;
      r.remainder      = op.dividend;
      r.divide_by_zero = 1'b1;
    end else begin
      r.quotient       = op.dividend / op.divisor;
      r.remainder      = op.dividend % op.divisor;
      r.divide_by_zero = 1'b0;
    end
    return r;
  endfunction

  // Sample both channels at the clock edge. A result is retired before a new
  // operand is queued, as both transfers may share one edge.
  always @(posedge clk) begin : watch
    udiv32_out_t want;
    if (rst) begin
      pending_divisions.delete();
      error_count  = 0;
      checked      = 0;
      zero_divides = 0;
    end else begin
      if (done) begin
        if (pending_divisions.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("ERROR %0t: unexpected result q=%h r=%h dz=%b", $realtime,
                     result.quotient, result.remainder, result.divide_by_zero);
        end else begin
          want = pending_divisions.pop_front();
          checked++;
          if (want.divide_by_zero)
            zero_divides++;
          if (result.quotient !== want.quotient || result.remainder !== want.remainder ||
              result.divide_by_zero !== want.divide_by_zero) begin
            error_count++;
            if (error_count <= 10)
              $display("ERROR %0t: q=%h r=%h dz=%b, expected q=%h r=%h dz=%b", $realtime,
                       result.quotient, result.remainder, result.divide_by_zero,
                       want.quotient, want.remainder, want.divide_by_zero);
          end
        end
      end
      if (start && !busy)
        pending_divisions.push_back(predict_division(operand));
    end
    pending <= pending_divisions.size();
  end

endmodule

>>> sim/tb_unsigned_divider_32_top.sv
// Testbench top for the 32-bit unsigned divider: drives operands and gives the verdict.
// Depends on udiv32_pkg, unsigned_divider_32_top and udiv32_checker.
`timescale 1ns / 100ps

module tb_unsigned_divider_32_top;
  import udiv32_pkg::*;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  udiv32_in_t  operand;
  logic        done;
  udiv32_out_t result;

  int error_count;
  int pending;
  int checked;
  int zero_divides;

  unsigned_divider_32_top DUT (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .operand (operand),
    .done    (done),
    .result  (result)
  );

  udiv32_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operand      (operand),
    .done         (done),
    .result       (result),
    .error_count  (error_count),
    .pending      (pending),
    .checked      (checked),
    .zero_divides (zero_divides)
  );

  // Free-running clock, 8 ns period.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop should the divider hang.
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Present one operand pair after an optional idle gap and hold it until the transfer.
  // Busy only moves on a rising edge, so it is read safely at the falling edge.
  task automatic issue_division(input logic [DATA_WIDTH-1:0] a,
                                input logic [DATA_WIDTH-1:0] b, input int gap);
    udiv32_in_t op;
    logic took;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op.dividend = a;
    op.divisor  = b;
    operand <= op;
    start   <= 1'b1;
    do begin
      @(negedge clk);
      took = !busy;
      @(posedge clk);
    end while (!took);
  endtask

  // Random value of random magnitude, so that short operands are common.
  function automatic logic [DATA_WIDTH-1:0] random_span();
    return $urandom >> $urandom_range(0, DATA_WIDTH - 1);
  endfunction

  initial begin : stimulus
    logic [DATA_WIDTH-1:0] a;
    logic [DATA_WIDTH-1:0] b;
    logic [DATA_WIDTH-1:0] top;
    logic [DATA_WIDTH-1:0] dir_a[$];
    logic [DATA_WIDTH-1:0] dir_b[$];
    bit quiet;
    int gap;

    top = '1;
    rst     <= 1'b1;
    start   <= 1'b0;
    operand <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pairs: zero divisors, extremes, divisors either side of 65536.
    dir_a = '{32'd0, top, 32'd0, top, top, top - 1, 32'd1, 32'd0, 32'd5,
              32'h1234_5678, 32'hFFFE_0001, top, 32'h8000_0000, 32'h7FFF_FFFF,
              32'd100, 32'd7, top, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0001_0000,
              32'hDEAD_BEEF};
    dir_b = '{32'd0, 32'd0, 32'd1, 32'd1, top, top, top, top, 32'h0000_FFFF,
              32'h0001_0000, 32'h0000_FFFF, 32'd2, 32'h8000_0000, 32'h8000_0000,
              32'd7, 32'd100, 32'h0001_0001, 32'h5555_5555, 32'hAAAA_AAAA,
              32'h0000_FFFF, 32'd3};
    foreach (dir_a[i])
      issue_division(dir_a[i], dir_b[i], $urandom_range(0, 19));

    // Random pairs, shaped by divisor class; some stretches run back to back.
    quiet = 1'b0;
    for (int n = 0; n < 1800; n++) begin
      if (n % 100 == 0)
        quiet = ($urandom_range(0, 2) == 0);
      a = $urandom;
      case ($urandom_range(0, 9))
        0: b = '0;
        1: b = $urandom_range(1, 255);
        2: b = $urandom_range(1, 16'hFFFF);
        3: b = $urandom_range(32'h0000_FFF0, 32'h0001_0010);
        4: b = $urandom;
        5: begin
          b = random_span() | 1;
          a = b * $urandom_range(0, 16'hFFFF) + $urandom_range(0, 3);
        end
        6: begin
          b = $urandom | 32'h8000_0000;
          a = b - $urandom_range(0, 1000);
        end
        7: begin
          b = random_span();
          a = b;
        end
        default: begin
          a = random_span();
          b = random_span();
        end
      endcase
      gap = quiet ? 0 : $urandom_range(0, 19);
      issue_division(a, b, gap);
    end
    start <= 1'b0;

    // Drain outstanding results, then watch for stray strobes.
    do @(negedge clk); while (pending != 0);
    repeat (40) @(posedge clk);

    $display("Checked %0d divisions, %0d of them by zero, with random gaps and bursts.",
             checked, zero_divides);
    if (error_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
rtl/udiv32_pkg.sv
rtl/udiv32_dp.sv
rtl/udiv32_ctrl.sv
rtl/unsigned_divider_32_top.sv
sim/udiv32_checker.sv
sim/tb_unsigned_divider_32_top.sv
